// ----- rtl/spbd_pkg.sv -----
// Shared types, constants and arithmetic helpers for the stereo peak bin decimator.
package spbd_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned PEAK_W   = 15;
    localparam int unsigned COUNT_W  = 24;
    localparam int unsigned BIN_W    = 6;
    localparam int unsigned LEVEL_W  = 8;

    localparam logic [PEAK_W-1:0]  FULL_SCALE = 15'h7FFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 24'hFFFFFF;
    localparam logic [SAMPLE_W-1:0] MOST_NEG  = 16'h8000;

    typedef struct packed {
        logic [BIN_W-1:0]  bin;
        logic [PEAK_W-1:0] peak;
        logic              tail;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // Absolute value of a sample, with the most negative code taken as full scale.
    function automatic logic [PEAK_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] neg;
        neg = (~s) + 16'd1;
        if (s == MOST_NEG) begin
            return FULL_SCALE;
        end else if (s[SAMPLE_W-1]) begin
            return neg[PEAK_W-1:0];
        end else begin
            return s[PEAK_W-1:0];
        end
    endfunction

    // floor(peak * 255 / 32767), using the divisor's form 2^15 - 1.
    function automatic logic [LEVEL_W-1:0] scale_level(input logic [PEAK_W-1:0] peak);
        logic [22:0] x;
        logic [22:0] y;
        x = {peak, 8'd0} - {8'd0, peak};
        y = x + {15'd0, x[22:15]} + 23'd1;
        return y[22:15];
    endfunction

endpackage

// ----- rtl/spbd_front.sv -----
// Front end: accepts frames, tracks the bin peak and count, and issues emit commands.
module spbd_front #(
    parameter int unsigned BINS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [spbd_pkg::COUNT_W-1:0]  i_cfg_data,
    input  logic                          i_frame_valid,
    input  logic [spbd_pkg::SAMPLE_W-1:0] i_left,
    input  logic [spbd_pkg::SAMPLE_W-1:0] i_right,
    input  logic                          i_eos,
    input  spbd_pkg::t_queue_status       i_q_status,
    output logic                          o_frame_ready,
    output logic                          o_push,
    output spbd_pkg::t_cmd                o_cmd
);

    localparam logic [spbd_pkg::BIN_W-1:0] LAST_BIN = spbd_pkg::BIN_W'(BINS - 1);

    logic [spbd_pkg::COUNT_W-1:0] r_fpb;
    logic [spbd_pkg::PEAK_W-1:0]  r_peak, n_peak;
    logic [spbd_pkg::COUNT_W-1:0] r_count, n_count;
    logic [spbd_pkg::BIN_W-1:0]   r_bin, n_bin;

    logic [spbd_pkg::PEAK_W-1:0]  mag_l, mag_r, val, peak_upd;
    logic [spbd_pkg::COUNT_W-1:0] count_upd, fpb_eff;
    logic                         accept, close;

    assign o_frame_ready = !i_q_status.full;
    assign accept        = i_frame_valid && o_frame_ready;

    always_comb begin
        mag_l     = spbd_pkg::magnitude(i_left);
        mag_r     = spbd_pkg::magnitude(i_right);
        val       = (mag_l > mag_r) ? mag_l : mag_r;
        peak_upd  = (val > r_peak) ? val : r_peak;
        count_upd = (r_count == spbd_pkg::COUNT_MAX) ? r_count : r_count + 24'd1;
        fpb_eff   = (r_fpb == '0) ? 24'd1 : r_fpb;
        close     = (r_bin != LAST_BIN) && (count_upd >= fpb_eff);
    end

    always_comb begin
        o_push     = accept && (close || i_eos);
        o_cmd.bin  = r_bin;
        o_cmd.peak = peak_upd;
        o_cmd.tail = i_eos;
    end

    always_comb begin
        n_peak  = r_peak;
        n_count = r_count;
        n_bin   = r_bin;
        if (accept) begin
            if (i_eos) begin
                n_peak  = '0;
                n_count = '0;
                n_bin   = '0;
            end else if (close) begin
                n_peak  = '0;
                n_count = '0;
                n_bin   = r_bin + 6'd1;
            end else begin
                n_peak  = peak_upd;
                n_count = count_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpb   <= 24'd1;
            r_peak  <= '0;
            r_count <= '0;
            r_bin   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_fpb <= i_cfg_data;
            end
            r_peak  <= n_peak;
            r_count <= n_count;
            r_bin   <= n_bin;
        end
    end

endmodule

// ----- rtl/spbd_queue.sv -----
// Short command queue between the front end and the emitter.
module spbd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  spbd_pkg::t_cmd          i_cmd,
    input  logic                    i_pop,
    output spbd_pkg::t_cmd          o_head,
    output spbd_pkg::t_queue_status o_status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    spbd_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_comb begin
        o_head         = r_mem[r_rd_ptr];
        o_status.empty = (r_count == '0);
        o_status.full  = (r_count == CNT_FULL);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/spbd_back.sv -----
// Back end: expands commands into bin reports and drives the output register.
module spbd_back #(
    parameter int unsigned BINS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  spbd_pkg::t_cmd               i_head,
    input  spbd_pkg::t_queue_status      i_q_status,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [spbd_pkg::BIN_W-1:0]   o_bin,
    output logic [spbd_pkg::LEVEL_W-1:0] o_level,
    output logic                         o_last
);

    localparam logic [spbd_pkg::BIN_W-1:0] LAST_BIN = spbd_pkg::BIN_W'(BINS - 1);

    logic                         r_active;
    logic [spbd_pkg::BIN_W-1:0]   r_bin;
    logic [spbd_pkg::LEVEL_W-1:0] r_level;
    logic                         r_tail;

    logic                         r_out_valid;
    logic [spbd_pkg::BIN_W-1:0]   r_out_bin;
    logic [spbd_pkg::LEVEL_W-1:0] r_out_level;

    logic                         load_ok, emit;
    logic [spbd_pkg::BIN_W-1:0]   src_bin;
    logic [spbd_pkg::LEVEL_W-1:0] src_level;
    logic                         src_tail, more;

    always_comb begin
        load_ok   = !r_out_valid || i_ready;
        src_bin   = r_active ? r_bin : i_head.bin;
        src_level = r_active ? r_level : spbd_pkg::scale_level(i_head.peak);
        src_tail  = r_active ? r_tail : i_head.tail;
        emit      = load_ok && (r_active || !i_q_status.empty);
        more      = src_tail && (src_bin != LAST_BIN);
        o_pop     = emit && !r_active;
    end

    assign o_valid = r_out_valid;
    assign o_bin   = r_out_bin;
    assign o_level = r_out_level;
    assign o_last  = (r_out_bin == LAST_BIN);

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_bin   <= src_bin;
            r_out_level <= src_level;
            r_bin       <= src_bin + 6'd1;
            r_level     <= '0;
            r_tail      <= src_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_active    <= more;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/stereo_peak_bin_decimator_unit.sv -----
// Top level of the stereo peak bin decimator: front end, command queue and emitter.
//
// The slave stream takes one stereo frame per beat: tdata carries the left
// sample in bits 15:0 and the right sample in bits 31:16, and tlast marks the
// final frame of a track. The master stream reports one overview bin per beat:
// tdata carries the bin number in bits 5:0 and the level in bits 13:6, and
// tlast is high on the last bin. The configuration channel writes the number
// of frames per bin; it is always ready and should only be written when idle.
// A frame is accepted every cycle while the command queue has room. A frame
// that closes a bin or ends a track is written into the command queue, and its
// first report reaches the master side from there through the output register.
// A track end produces one beat per cycle while the receiver takes them, for the
// current bin and every remaining bin, up to BINS beats, all from the emitter
// loop; frames keep flowing into the queue meanwhile until it fills.
// When the receiver stalls, the output register holds its beat, the emitter
// and queue stop, and the slave side stalls once the queue is full.
// Reset clears the bin state and the queue and sets frames per bin to 1.
module stereo_peak_bin_decimator_unit #(
    parameter int unsigned BINS        = 64,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data,    // frames_per_bin
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,     // left_sample, right_sample
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,     // bin_number, level, zero padding
    output logic        o_m_tlast
);

    spbd_pkg::t_cmd          push_cmd, head_cmd;
    spbd_pkg::t_queue_status q_status;
    logic                    push, pop;
    logic [spbd_pkg::BIN_W-1:0]   out_bin;
    logic [spbd_pkg::LEVEL_W-1:0] out_level;

    assign o_cfg_ready = 1'b1;

    spbd_front #(.BINS(BINS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_frame_valid (i_s_tvalid),
        .i_left        (i_s_tdata[15:0]),
        .i_right       (i_s_tdata[31:16]),
        .i_eos         (i_s_tlast),
        .i_q_status    (q_status),
        .o_frame_ready (o_s_tready),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    spbd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    spbd_back #(.BINS(BINS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_cmd),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_bin      (out_bin),
        .o_level    (out_level),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, out_level, out_bin};

endmodule

// ----- rtl/spbd_checker.sv -----
// Port-level checker for the stereo peak bin decimator, bound to the top level.
module spbd_checker #(
    parameter int unsigned BINS = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [23:0] i_cfg_data,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast
);

    localparam logic [5:0] LAST_BIN = 6'(BINS - 1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("Stalled output beat changed.");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tdata[5:0] == LAST_BIN)))
        else $error("Last-bin flag does not match the bin number.");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:14] == 2'b00))
        else $error("Output padding bits are not zero.");

    a_bin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) ##1 (o_m_tvalid && i_m_tready) |->
            (o_m_tdata[5:0] == $past(o_m_tdata[5:0]) + 6'd1))
        else $error("Bins were reported out of order.");

endmodule

bind stereo_peak_bin_decimator_unit spbd_checker #(.BINS(BINS)) u_spbd_checker (.*);
